// File: design/csqv_pkg.sv
`default_nettype none
package csqv_pkg;

  localparam int CFG_W  = 9;
  localparam int FACE_W = 3;
  localparam int IDX_W  = 8;
  localparam int D_W    = 9;
  localparam int MAG_W  = 9;
  localparam int SUM_W  = 20;
  localparam int POS_W  = 16;

  localparam logic [FACE_W-1:0] FACE_LAST = 3'd5;

  // One classified quad as it waits between the front and the back.
  typedef struct packed {
    logic [FACE_W-1:0] face;
    logic [IDX_W-1:0]  col;
    logic [IDX_W-1:0]  row;
    logic [D_W-1:0]    d;
    logic              bad;
  } quad_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_CORNER,
    B_START,
    B_WAIT,
    B_EMIT
  } back_state_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_SQRT,
    S_DONE
  } scale_state_t;

  // Faces 0, 3 and 4 share one triangle winding; the others run reversed.
  function automatic logic wind_fwd(input logic [FACE_W-1:0] face);
    return (face == 3'd0) || (face == 3'd3) || (face == 3'd4);
  endfunction

  // Corner code: bit 0 selects col+1, bit 1 selects row+1.
  function automatic logic [1:0] wind_corner(input logic fwd, input logic [2:0] k);
    logic [1:0] c;
    c = 2'd0;
    if (fwd) begin
      case (k)
        3'd0: c = 2'd0;
        3'd1: c = 2'd1;
        3'd2: c = 2'd2;
        3'd3: c = 2'd3;
        3'd4: c = 2'd2;
        default: c = 2'd1;
      endcase
    end else begin
      case (k)
        3'd0: c = 2'd2;
        3'd1: c = 2'd1;
        3'd2: c = 2'd0;
        3'd3: c = 2'd1;
        3'd4: c = 2'd2;
        default: c = 2'd3;
      endcase
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// File: design/csqv_front.sv
`default_nettype none
module csqv_front #(
  parameter int MAX_GRID = 256
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [csqv_pkg::CFG_W-1:0]    cfg_wr_data,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [23:0]                   in_tdata,
  input  wire logic                          q_full,
  output logic                               q_push,
  output csqv_pkg::quad_t                    q_data
);

  logic [csqv_pkg::CFG_W-1:0] grid_r;
  logic [csqv_pkg::CFG_W-1:0] n_eff;
  logic [csqv_pkg::FACE_W-1:0] face;
  logic [csqv_pkg::IDX_W-1:0] col;
  logic [csqv_pkg::IDX_W-1:0] row;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_r <= 9'd16;
    end else if (cfg_wr_en) begin
      grid_r <= cfg_wr_data;
    end
  end

  always_comb begin
    n_eff = grid_r;
    if (n_eff < 9'd2) n_eff = 9'd2;
    if (32'(n_eff) > MAX_GRID) n_eff = 9'(MAX_GRID);
  end

  assign face = in_tdata[2:0];
  assign col  = in_tdata[10:3];
  assign row  = in_tdata[18:11];

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    q_data.face = face;
    q_data.col  = col;
    q_data.row  = row;
    q_data.d    = n_eff - 9'd1;
    q_data.bad  = (face > csqv_pkg::FACE_LAST)
               || ({2'b00, col} + 10'd2 > {1'b0, n_eff})
               || ({2'b00, row} + 10'd2 > {1'b0, n_eff});
  end

endmodule
`default_nettype wire

// File: design/csqv_queue.sv
`default_nettype none
module csqv_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire csqv_pkg::quad_t  push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  empty,
  output csqv_pkg::quad_t       pop_data
);

  csqv_pkg::quad_t mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push && !full) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push && !full) wr_ptr_r <= !wr_ptr_r;
      if (pop && !empty) rd_ptr_r <= !rd_ptr_r;
      count_r <= count_r + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
    end
  end

endmodule
`default_nettype wire

// File: design/csqv_scale.sv
`default_nettype none
// Computes round(mag * 2^FRAC_BITS / sqrt(sum)) as floor((isqrt(Q) + 1) / 2),
// with Q = floor(mag^2 * 4^(FRAC_BITS+1) / sum), one bit per cycle.
module csqv_scale #(
  parameter int FRAC_BITS = 14
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [csqv_pkg::MAG_W-1:0]  mag,
  input  wire logic                        neg,
  input  wire logic [csqv_pkg::SUM_W-1:0]  sum,
  output logic                             done,
  output logic [csqv_pkg::POS_W-1:0]       res
);

  localparam int DIV_N = 2 * FRAC_BITS + 2;
  localparam int QW    = 2 * FRAC_BITS + 3;
  localparam int RW    = FRAC_BITS + 2;
  localparam int SQW   = 2 * RW;
  localparam int CW    = $clog2(DIV_N);

  csqv_pkg::scale_state_t state_r, state_nxt;

  logic [csqv_pkg::SUM_W-1:0] sum_r;
  logic [csqv_pkg::SUM_W-1:0] rem_r;
  logic [QW-1:0]              quo_r;
  logic [SQW-1:0]             qsh_r;
  logic [RW-1:0]              root_r;
  logic [RW:0]                srem_r;
  logic [CW-1:0]              cnt_r;
  logic                       neg_r;

  logic [2*csqv_pkg::MAG_W-1:0] msq;
  logic                         msq_ge;
  logic [csqv_pkg::SUM_W:0]     remsh;
  logic                         qbit;
  logic [RW+2:0]                strial;
  logic [RW+2:0]                stest;
  logic                         sbit;
  logic [RW:0]                  root_inc;
  logic [31:0]                  mag_ext;

  assign msq    = mag * mag;
  assign msq_ge = {2'b00, msq} >= sum;
  assign remsh  = {rem_r, 1'b0};
  assign qbit   = remsh >= {1'b0, sum_r};
  assign stest  = {srem_r, qsh_r[SQW-1 -: 2]};
  assign strial = {1'b0, root_r, 2'b01};
  assign sbit   = stest >= strial;
  assign root_inc = {1'b0, root_r} + (RW+1)'(1);
  assign mag_ext  = 32'(root_inc[RW:1]);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      csqv_pkg::S_IDLE: if (start) state_nxt = csqv_pkg::S_DIV;
      csqv_pkg::S_DIV:  if (cnt_r == CW'(DIV_N - 1)) state_nxt = csqv_pkg::S_SQRT;
      csqv_pkg::S_SQRT: if (cnt_r == CW'(RW - 1)) state_nxt = csqv_pkg::S_DONE;
      csqv_pkg::S_DONE: state_nxt = csqv_pkg::S_IDLE;
      default: state_nxt = csqv_pkg::S_IDLE;
    endcase
  end

  // The root is final while done is high, so the result is taken from it directly.
  always_comb begin
    done = (state_r == csqv_pkg::S_DONE);
    res  = neg_r ? csqv_pkg::POS_W'(32'd0 - mag_ext) : mag_ext[csqv_pkg::POS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= csqv_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    case (state_r)
      csqv_pkg::S_IDLE: begin
        sum_r <= sum;
        neg_r <= neg;
        rem_r <= msq_ge ? csqv_pkg::SUM_W'({2'b00, msq} - sum) : csqv_pkg::SUM_W'(msq);
        quo_r <= QW'(msq_ge);
        cnt_r <= '0;
      end
      csqv_pkg::S_DIV: begin
        rem_r <= qbit ? csqv_pkg::SUM_W'(remsh - {1'b0, sum_r})
                      : csqv_pkg::SUM_W'(remsh);
        quo_r <= {quo_r[QW-2:0], qbit};
        if (cnt_r == CW'(DIV_N - 1)) begin
          qsh_r  <= SQW'({quo_r[QW-2:0], qbit});
          root_r <= '0;
          srem_r <= '0;
          cnt_r  <= '0;
        end else begin
          cnt_r <= cnt_r + CW'(1);
        end
      end
      csqv_pkg::S_SQRT: begin
        srem_r <= sbit ? (RW+1)'(stest - strial) : (RW+1)'(stest);
        root_r <= {root_r[RW-2:0], sbit};
        qsh_r  <= qsh_r << 2;
        cnt_r  <= cnt_r + CW'(1);
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// File: design/csqv_back.sv
`default_nettype none
module csqv_back #(
  parameter int FRAC_BITS = 14
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          q_empty,
  input  wire csqv_pkg::quad_t q_data,
  output logic               q_pop,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [47:0]        out_tdata,
  output logic               out_tlast,
  output logic               out_tuser
);

  localparam int PW = csqv_pkg::POS_W;

  csqv_pkg::back_state_t state_r, state_nxt;

  csqv_pkg::quad_t quad_r;
  logic [1:0] cidx_r;
  logic [2:0] k_r;
  logic       fwd_r;

  logic [PW-1:0] cu_r [4];
  logic [PW-1:0] cv_r [4];
  logic [PW-1:0] cw_r [4];

  logic [csqv_pkg::SUM_W-1:0] sum_r;
  logic [csqv_pkg::MAG_W-1:0] mp_r, mq_r, md_r;
  logic                       np_r, nq_r;

  logic        out_valid_r;
  logic [47:0] out_data_r;
  logic        out_last_r;
  logic        out_user_r;

  logic                  lane_start;
  logic [2:0]            lane_done;
  logic [PW-1:0]         res_p, res_q, res_d;
  logic                  load_ok;

  logic [8:0]  r_c, c_c;
  logic [10:0] p_s, q_s;
  logic [csqv_pkg::MAG_W-1:0] mp_c, mq_c;
  logic [1:0]  sel;
  logic [PW-1:0] u_v, v_v, w_v, wn_v;
  logic [PW-1:0] x_v, y_v, z_v;

  assign load_ok = !out_valid_r || out_tready;

  // Corner setup: p = d - 2r and q = d - 2c are odd-or-even signed offsets.
  assign r_c  = {1'b0, quad_r.row} + 9'(cidx_r[1]);
  assign c_c  = {1'b0, quad_r.col} + 9'(cidx_r[0]);
  assign p_s  = {2'b00, quad_r.d} - {1'b0, r_c, 1'b0};
  assign q_s  = {2'b00, quad_r.d} - {1'b0, c_c, 1'b0};
  assign mp_c = p_s[10] ? 9'(11'd0 - p_s) : p_s[8:0];
  assign mq_c = q_s[10] ? 9'(11'd0 - q_s) : q_s[8:0];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      csqv_pkg::B_IDLE:   if (!q_empty) state_nxt = q_data.bad ? csqv_pkg::B_EMIT
                                                               : csqv_pkg::B_CORNER;
      csqv_pkg::B_CORNER: state_nxt = csqv_pkg::B_START;
      csqv_pkg::B_START:  state_nxt = csqv_pkg::B_WAIT;
      csqv_pkg::B_WAIT:   if (lane_done[0]) state_nxt = (cidx_r == 2'd3) ? csqv_pkg::B_EMIT
                                                                         : csqv_pkg::B_CORNER;
      csqv_pkg::B_EMIT:   if (load_ok && k_r == 3'd5) state_nxt = csqv_pkg::B_IDLE;
      default:            state_nxt = csqv_pkg::B_IDLE;
    endcase
  end

  always_comb begin
    q_pop      = (state_r == csqv_pkg::B_IDLE) && !q_empty;
    lane_start = (state_r == csqv_pkg::B_START);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= csqv_pkg::B_IDLE;
    else        state_r <= state_nxt;
  end

  csqv_scale #(.FRAC_BITS(FRAC_BITS)) u_lane_p (
    .clk(clk), .rst_n(rst_n), .start(lane_start), .mag(mp_r), .neg(np_r),
    .sum(sum_r), .done(lane_done[0]), .res(res_p)
  );
  csqv_scale #(.FRAC_BITS(FRAC_BITS)) u_lane_q (
    .clk(clk), .rst_n(rst_n), .start(lane_start), .mag(mq_r), .neg(nq_r),
    .sum(sum_r), .done(lane_done[1]), .res(res_q)
  );
  csqv_scale #(.FRAC_BITS(FRAC_BITS)) u_lane_d (
    .clk(clk), .rst_n(rst_n), .start(lane_start), .mag(md_r), .neg(1'b0),
    .sum(sum_r), .done(lane_done[2]), .res(res_d)
  );

  always_ff @(posedge clk) begin
    if (q_pop) begin
      quad_r <= q_data;
      fwd_r  <= csqv_pkg::wind_fwd(q_data.face);
    end
    if (state_r == csqv_pkg::B_CORNER) begin
      mp_r  <= mp_c;
      mq_r  <= mq_c;
      md_r  <= quad_r.d;
      np_r  <= p_s[10];
      nq_r  <= q_s[10];
      sum_r <= csqv_pkg::SUM_W'(mp_c) * csqv_pkg::SUM_W'(mp_c)
             + csqv_pkg::SUM_W'(mq_c) * csqv_pkg::SUM_W'(mq_c)
             + csqv_pkg::SUM_W'(quad_r.d) * csqv_pkg::SUM_W'(quad_r.d);
    end
    if (state_r == csqv_pkg::B_WAIT && lane_done[0]) begin
      cu_r[cidx_r] <= res_p;
      cv_r[cidx_r] <= res_q;
      cw_r[cidx_r] <= res_d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cidx_r <= 2'd0;
      k_r    <= 3'd0;
    end else begin
      if (q_pop) begin
        cidx_r <= 2'd0;
        k_r    <= 3'd0;
      end else begin
        if (state_r == csqv_pkg::B_WAIT && lane_done[0]) cidx_r <= cidx_r + 2'd1;
        if (state_r == csqv_pkg::B_EMIT && load_ok) k_r <= k_r + 3'd1;
      end
    end
  end

  // Vertex selection and per-face axis mapping.
  assign sel  = csqv_pkg::wind_corner(fwd_r, k_r);
  assign u_v  = cu_r[sel];
  assign v_v  = cv_r[sel];
  assign w_v  = cw_r[sel];
  assign wn_v = PW'(0) - w_v;

  always_comb begin
    x_v = u_v;
    y_v = v_v;
    z_v = w_v;
    case (quad_r.face)
      3'd0: begin x_v = wn_v; y_v = u_v; z_v = v_v; end
      3'd1: begin x_v = w_v;  y_v = u_v; z_v = v_v; end
      3'd2: begin x_v = u_v;  y_v = wn_v; z_v = v_v; end
      3'd3: begin x_v = u_v;  y_v = w_v; z_v = v_v; end
      3'd4: begin x_v = u_v;  y_v = v_v; z_v = wn_v; end
      default: begin x_v = u_v; y_v = v_v; z_v = w_v; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state_r == csqv_pkg::B_EMIT && load_ok) begin
      out_data_r <= quad_r.bad ? 48'd0 : {z_v, y_v, x_v};
      out_last_r <= (k_r == 3'd5);
      out_user_r <= quad_r.bad;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == csqv_pkg::B_EMIT && load_ok) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

  a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (lane_done[0] == lane_done[1]) && (lane_done[1] == lane_done[2]))
    else $error("scale lanes out of step");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    lane_done[0] |-> (state_r == csqv_pkg::B_WAIT))
    else $error("lane finished outside of wait state");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_user_r) |-> (out_data_r == 48'd0))
    else $error("rejected quad carries nonzero coordinates");

  a_emit_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == csqv_pkg::B_EMIT && load_ok && k_r == 3'd5) |=> (out_tlast && out_tvalid))
    else $error("sixth vertex not marked last");

endmodule
`default_nettype wire

// File: design/cube_sphere_quad_vertex_gen_core.sv
`default_nettype none
// Channel  Dir  Fields (low bit first)
// in_      in   tdata: face[2:0] col[10:3] row[18:11]
// out_     out  tdata: pos_x[15:0] pos_y[31:16] pos_z[47:32]; tlast: last; tuser: bad_quad
// cfg_     in   wr_data: grid_size
//
// A good quad passes each of its four corners in turn through the three shared
// divide and square-root lanes.
// A rejected quad streams its six zero vertices at one per cycle unless out_tready stalls it.
// Reset is synchronous and active low; grid_size comes up as 16.
// A two-entry queue keeps the input open while the back end works or stalls, until both entries fill.
module cube_sphere_quad_vertex_gen_core #(
  parameter int MAX_GRID  = 256,
  parameter int FRAC_BITS = 14
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [8:0]  cfg_wr_data,   // grid_size
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,      // face, col, row
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,     // pos_x, pos_y, pos_z
  output logic             out_tlast,
  output logic             out_tuser      // bad_quad
);

  csqv_pkg::quad_t push_data;
  csqv_pkg::quad_t pop_data;
  logic q_push, q_full, q_pop, q_empty;

  csqv_front #(.MAX_GRID(MAX_GRID)) u_front (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .q_full(q_full), .q_push(q_push), .q_data(push_data)
  );

  csqv_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_data(push_data), .full(q_full),
    .pop(q_pop), .empty(q_empty), .pop_data(pop_data)
  );

  csqv_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_empty(q_empty), .q_data(pop_data), .q_pop(q_pop),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast), .out_tuser(out_tuser)
  );

endmodule
`default_nettype wire
